>>> hdl/rudi_pkg.sv
// Shared types and constants for the ray versus unit disk intersection unit.
package rudi_pkg;

    localparam int NUM_REGS    = 6;
    localparam int DIV_STEPS   = 31;
    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_M00_M01 = 3'd0;
    localparam logic [2:0] REG_M02_T0  = 3'd1;
    localparam logic [2:0] REG_M10_M11 = 3'd2;
    localparam logic [2:0] REG_M12_T1  = 3'd3;
    localparam logic [2:0] REG_M20_M21 = 3'd4;
    localparam logic [2:0] REG_M22_T2  = 3'd5;

    // One divider step: partial remainder, quotient bits and side data.
    typedef struct packed {
        logic [63:0]        rem;
        logic [31:0]        den;
        logic [30:0]        quo;
        logic               tovf;
        logic               neg;
        logic               dz_zero;
        logic               ovf;
        logic               en;
        logic [30:0]        max_dist;
        logic signed [31:0] wo0;
        logic signed [31:0] wo1;
        logic signed [31:0] wd0;
        logic signed [31:0] wd1;
    } t_div;

endpackage

>>> hdl/ray_unit_disk_intersect.sv
// Ray versus unit disk intersection unit, fully pipelined top level.
//
// One ray per clock while the output is taken. Each ray is moved into
// object space by an affine transform held in six 64-bit APB registers,
// the crossing with z = 0 is found by a 31-step pipelined restoring
// divider (one quotient bit per stage), and the crossing point is tested
// against the unit disk. There are 40 register stages, most of them in the
// divider chain. Every stage holds its own valid bit and the ready chain
// lets bubbles collapse, so a held output does not stop new transfers while
// empty stages remain. On a miss hit_dist is all ones; local_u/local_v
// always give the saturated crossing point. Registers must be written only
// while the pipeline is empty; the block itself does not enforce this.
module ray_unit_disk_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_dist[30:0], pad
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [223:0] i_s_tdata,
    // tuser: enable
    input  logic         i_s_tuser,
    // tdata: hit_dist[30:0], local_u, local_v, pad
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,
    // tuser: hit
    output logic         o_m_tuser,
    // config
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import rudi_pkg::*;

    localparam int NST = 40;
    localparam int SQW = 2 * FRAC_BITS + 4;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic [SQW:0] ONE_SQ = (SQW+1)'(1) << (2 * FRAC_BITS);
    localparam logic signed [63:0] S32_MAX = 64'sh7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = -64'sh8000_0000;

    // ---------------- configuration registers ----------------
    logic [63:0] r_xf [NUM_REGS];
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf[REG_M00_M01] <= 64'(ONE) << 32;
            r_xf[REG_M02_T0]  <= '0;
            r_xf[REG_M10_M11] <= 64'(ONE);
            r_xf[REG_M12_T1]  <= '0;
            r_xf[REG_M20_M21] <= '0;
            r_xf[REG_M22_T2]  <= 64'(ONE) << 32;
        end else if (psel && penable && pwrite && pready) begin
            if (cfg_idx < 3'(NUM_REGS)) begin
                r_xf[cfg_idx] <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx < 3'(NUM_REGS)) begin
            prdata = r_xf[cfg_idx];
        end
    end

    logic signed [31:0] m [3][3];
    logic signed [31:0] tr [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            m[r][0] = r_xf[2*r][63:32];
            m[r][1] = r_xf[2*r][31:0];
            m[r][2] = r_xf[2*r+1][63:32];
            tr[r]   = r_xf[2*r+1][31:0];
        end
    end

    // ---------------- valid / ready chain ----------------
    logic [NST-1:0] r_v;
    logic [NST:0]   rdy;

    always_comb begin
        rdy[NST] = i_m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_s_tvalid : r_v[k-1];
                end
            end
        end
    end

    assign o_s_tready = rdy[0];

    // ---------------- stage 0: input register ----------------
    logic signed [31:0] r_o [3];
    logic signed [31:0] r_d [3];
    logic [30:0]        r_md0;
    logic               r_en0;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int c = 0; c < 3; c++) begin
                r_o[c] <= i_s_tdata[32*c +: 32];
                r_d[c] <= i_s_tdata[96 + 32*c +: 32];
            end
            r_md0 <= i_s_tdata[222:192];
            r_en0 <= i_s_tuser;
        end
    end

    // ---------------- stage 1: products, floored ----------------
    logic signed [63:0] r_po [3][3];
    logic signed [63:0] r_pd [3][3];
    logic [30:0]        r_md1;
    logic               r_en1;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_po[r][c] <= (64'(m[r][c]) * 64'(r_o[c])) >>> FRAC_BITS;
                    r_pd[r][c] <= (64'(m[r][c]) * 64'(r_d[c])) >>> FRAC_BITS;
                end
            end
            r_md1 <= r_md0;
            r_en1 <= r_en0;
        end
    end

    // ---------------- stage 2: sums and saturation ----------------
    logic signed [63:0] so [3];
    logic signed [63:0] sd [3];
    logic signed [31:0] n_wo [3];
    logic signed [31:0] n_wd [3];
    logic               n_ovf;

    always_comb begin
        n_ovf = 1'b0;
        for (int r = 0; r < 3; r++) begin
            so[r] = 64'(tr[r]) + r_po[r][0] + r_po[r][1] + r_po[r][2];
            sd[r] = r_pd[r][0] + r_pd[r][1] + r_pd[r][2];
            if (so[r] > S32_MAX) begin
                n_wo[r] = 32'sh7FFF_FFFF; n_ovf = 1'b1;
            end else if (so[r] < S32_MIN) begin
                n_wo[r] = -32'sh8000_0000; n_ovf = 1'b1;
            end else begin
                n_wo[r] = so[r][31:0];
            end
            if (sd[r] > S32_MAX) begin
                n_wd[r] = 32'sh7FFF_FFFF; n_ovf = 1'b1;
            end else if (sd[r] < S32_MIN) begin
                n_wd[r] = -32'sh8000_0000; n_ovf = 1'b1;
            end else begin
                n_wd[r] = sd[r][31:0];
            end
        end
    end

    logic signed [31:0] r_wo [3];
    logic signed [31:0] r_wd [3];
    logic               r_ovf2;
    logic [30:0]        r_md2;
    logic               r_en2;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_wo   <= n_wo;
            r_wd   <= n_wd;
            r_ovf2 <= n_ovf;
            r_md2  <= r_md1;
            r_en2  <= r_en1;
        end
    end

    // ---------------- stage 3: divider setup ----------------
    t_div        n_dp, r_dp;
    logic [31:0] oz_abs;

    always_comb begin
        oz_abs       = r_wo[2][31] ? 32'(-r_wo[2]) : 32'(r_wo[2]);
        n_dp.den     = r_wd[2][31] ? 32'(-r_wd[2]) : 32'(r_wd[2]);
        n_dp.rem     = 64'(oz_abs) << FRAC_BITS;
        n_dp.quo     = '0;
        // quotient needs more than 31 bits
        n_dp.tovf    = n_dp.rem >= (64'(n_dp.den) << DIV_STEPS);
        n_dp.neg     = (r_wo[2] != 0) && (r_wo[2][31] == r_wd[2][31]);
        n_dp.dz_zero = r_wd[2] == 0;
        n_dp.ovf     = r_ovf2;
        n_dp.en      = r_en2;
        n_dp.max_dist = r_md2;
        n_dp.wo0     = r_wo[0];
        n_dp.wo1     = r_wo[1];
        n_dp.wd0     = r_wd[0];
        n_dp.wd1     = r_wd[1];
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_dp <= n_dp;
        end
    end

    // ---------------- stages 4..34: one quotient bit each ----------------
    t_div r_dv [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        t_div        src, n_st;
        logic [63:0] cmp;
        assign src = (j == 0) ? r_dp : r_dv[(j == 0) ? 0 : j-1];
        always_comb begin
            n_st = src;
            cmp  = 64'(src.den) << (DIV_STEPS - 1 - j);
            if (src.rem >= cmp) begin
                n_st.rem = src.rem - cmp;
                n_st.quo[DIV_STEPS-1-j] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (rdy[4+j]) begin
                r_dv[j] <= n_st;
            end
        end
    end

    // ---------------- stage 35: signed distance ----------------
    t_div               dq;
    logic [30:0]        mag;
    logic signed [31:0] r_t;
    logic               r_pre35;
    logic signed [31:0] r_wo0_35, r_wo1_35, r_wd0_35, r_wd1_35;

    assign dq  = r_dv[DIV_STEPS-1];
    assign mag = dq.tovf ? DIST_MAX : dq.quo;

    always_ff @(posedge i_clk) begin
        if (rdy[35]) begin
            if (dq.dz_zero) begin
                r_t <= '0;
            end else if (dq.neg) begin
                r_t <= -$signed({1'b0, mag});
            end else begin
                r_t <= $signed({1'b0, mag});
            end
            // everything but the box and disk tests
            r_pre35  <= dq.en && !dq.ovf && !dq.dz_zero && !dq.tovf &&
                        !(dq.neg && mag != 0) && (mag <= dq.max_dist);
            r_wo0_35 <= dq.wo0;
            r_wo1_35 <= dq.wo1;
            r_wd0_35 <= dq.wd0;
            r_wd1_35 <= dq.wd1;
        end
    end

    // ---------------- stage 36: t * d' ----------------
    logic signed [63:0] r_pu, r_pv;
    logic signed [31:0] r_t36, r_wo0_36, r_wo1_36;
    logic               r_pre36;

    always_ff @(posedge i_clk) begin
        if (rdy[36]) begin
            r_pu     <= 64'(r_t) * 64'(r_wd0_35);
            r_pv     <= 64'(r_t) * 64'(r_wd1_35);
            r_t36    <= r_t;
            r_wo0_36 <= r_wo0_35;
            r_wo1_36 <= r_wo1_35;
            r_pre36  <= r_pre35;
        end
    end

    // ---------------- stage 37: crossing point ----------------
    logic signed [63:0] r_lx, r_ly;
    logic signed [31:0] r_t37;
    logic               r_pre37;

    always_ff @(posedge i_clk) begin
        if (rdy[37]) begin
            r_lx    <= 64'(r_wo0_36) + (r_pu >>> FRAC_BITS);
            r_ly    <= 64'(r_wo1_36) + (r_pv >>> FRAC_BITS);
            r_t37   <= r_t36;
            r_pre37 <= r_pre36;
        end
    end

    // ---------------- stage 38: box test, squares, saturation ----------------
    logic signed [FRAC_BITS+1:0] lxs, lys;
    logic signed [SQW-1:0]       sqx, sqy;
    logic signed [31:0]          n_u, n_v;

    assign lxs = r_lx[FRAC_BITS+1:0];
    assign lys = r_ly[FRAC_BITS+1:0];
    assign sqx = SQW'(lxs) * SQW'(lxs);
    assign sqy = SQW'(lys) * SQW'(lys);

    always_comb begin
        if (r_lx > S32_MAX)      n_u = 32'sh7FFF_FFFF;
        else if (r_lx < S32_MIN) n_u = -32'sh8000_0000;
        else                     n_u = r_lx[31:0];
        if (r_ly > S32_MAX)      n_v = 32'sh7FFF_FFFF;
        else if (r_ly < S32_MIN) n_v = -32'sh8000_0000;
        else                     n_v = r_ly[31:0];
    end

    logic [SQW-1:0]     r_sqx, r_sqy;
    logic               r_box, r_pre38;
    logic signed [31:0] r_t38, r_u38, r_v38;

    always_ff @(posedge i_clk) begin
        if (rdy[38]) begin
            r_sqx   <= sqx;
            r_sqy   <= sqy;
            r_box   <= (r_lx <= ONE) && (r_lx >= -ONE) && (r_ly <= ONE) && (r_ly >= -ONE);
            r_pre38 <= r_pre37;
            r_t38   <= r_t37;
            r_u38   <= n_u;
            r_v38   <= n_v;
        end
    end

    // ---------------- stage 39: disk test, output register ----------------
    logic        hit;
    logic        r_hit;
    logic [30:0] r_dist;
    logic [31:0] r_lu, r_lv;

    assign hit = r_pre38 && r_box && (({1'b0, r_sqx} + {1'b0, r_sqy}) <= ONE_SQ);

    always_ff @(posedge i_clk) begin
        if (rdy[39]) begin
            r_hit  <= hit;
            r_dist <= hit ? r_t38[30:0] : DIST_MAX;
            r_lu   <= r_u38;
            r_lv   <= r_v38;
        end
    end

    assign o_m_tvalid = r_v[NST-1];
    assign o_m_tuser  = r_hit;
    assign o_m_tdata  = {1'b0, r_lv, r_lu, r_dist};

endmodule

>>> hdl/rudi_chk.sv
// Port-level checker for the ray versus unit disk intersection unit.
module rudi_chk #(
    parameter int FRAC_BITS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [95:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        pready
);
    import rudi_pkg::*;

    localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;

    // Output register empties on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled transfer changed");

    // Miss carries the all-ones distance
    a_miss_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[30:0] == DIST_MAX)
        else $error("miss without max distance");

    // A hit lies inside the unit square
    a_hit_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            $signed(o_m_tdata[62:31]) <= ONE32 && $signed(o_m_tdata[62:31]) >= -ONE32 &&
            $signed(o_m_tdata[94:63]) <= ONE32 && $signed(o_m_tdata[94:63]) >= -ONE32)
        else $error("hit outside unit disk bounds");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind ray_unit_disk_intersect rudi_chk #(.FRAC_BITS(FRAC_BITS)) u_rudi_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);
